// ----- src/swpr_pkg.sv -----
// Package for the stop-and-wait packet receiver.
// Holds the packet and event codes, the decoded command and the result record.
// It depends on nothing and every other file in src uses it.
package swpr_pkg;

  localparam logic [2:0] KIND_DATA      = 3'd0;
  localparam logic [2:0] KIND_LAST_DATA = 3'd1;
  localparam logic [2:0] KIND_PEER_ACK  = 3'd2;
  localparam logic [2:0] KIND_PEER_NACK = 3'd3;
  localparam logic [2:0] KIND_TERM      = 3'd4;

  localparam logic [2:0] EV_STAGED      = 3'd0;
  localparam logic [2:0] EV_SEND_ACK    = 3'd1;
  localparam logic [2:0] EV_SEND_NACK   = 3'd2;
  localparam logic [2:0] EV_PEER_ACKED  = 3'd3;
  localparam logic [2:0] EV_PEER_NACKED = 3'd4;
  localparam logic [2:0] EV_CLOSED      = 3'd5;

  localparam int ADDR_W = 16;
  localparam int LEN_W  = 17;

  typedef enum logic [2:0] {
    OP_DATA,
    OP_FINAL,
    OP_PEER_ACK,
    OP_PEER_NACK,
    OP_TERM,
    OP_NONE
  } op_t;

  typedef struct packed {
    op_t         op;
    logic [7:0]  data;
    logic        last;
    logic [31:0] carried;
  } cmd_t;

  typedef struct packed {
    logic [2:0]        event_kind;
    logic              byte_valid;
    logic [ADDR_W-1:0] write_address;
    logic [7:0]        write_byte;
    logic [LEN_W-1:0]  message_length;
    logic              message_done;
  } result_t;

endpackage

// ----- src/stop_wait_packet_receiver_unit.sv -----
// Stop-and-wait packet receiver with additive checksum, top level.
// Connects the front end, the command queue and the execution side.
// Depends on swpr_pkg, swpr_front, swpr_queue and swpr_back.
//
// The slave channel takes one packet byte per transfer: the packet kind in
// s_tuser, the last-byte mark in s_tlast, and the byte and carried checksum in
// s_tdata. The master channel gives exactly one result transfer per input
// transfer, in order: event kind and byte-valid flag in m_tuser, message
// completion in m_tlast, and write address, write byte and committed length
// in m_tdata.
// A transfer is classified on entry and written into a two-entry queue; the
// execution side pops it and registers the result, so the queue entry and
// the output register lie between input and result. While the master side is
// ready, the block sustains one transfer per cycle. The execution step (one
// 32-bit sum and compare plus the address add) is combinational and sets that rate.
// Reset empties the queue and the output register, clears the sum, index and
// committed length, and opens the link. When the receiver stalls m_tready,
// the result holds, the queue fills, and s_tready drops once both entries
// are taken.
module stop_wait_packet_receiver_unit #(
  parameter int PAYLOAD_MAX = 1024,
  parameter int MESSAGE_MAX = 65536
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [39:0] s_tdata,   // payload_byte [7:0], carried_sum [39:8]
  input  logic [2:0]  s_tuser,   // packet_kind [2:0]
  input  logic        s_tlast,
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [47:0] m_tdata,   // write_address [15:0], write_byte [23:16],
                                 // message_length [40:24], zero [47:41]
  output logic [3:0]  m_tuser,   // event_kind [2:0], byte_valid [3]
  output logic        m_tlast
);

  swpr_pkg::cmd_t    front_cmd;
  swpr_pkg::cmd_t    head_cmd;
  swpr_pkg::result_t res;
  logic              q_full;
  logic              q_not_empty;
  logic              q_pop;
  logic              push;

  assign s_tready = !q_full;
  assign push     = s_tvalid && !q_full;

  swpr_front u_front (
    .kind    (s_tuser),
    .data    (s_tdata[7:0]),
    .last    (s_tlast),
    .carried (s_tdata[39:8]),
    .cmd     (front_cmd)
  );

  swpr_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_cmd  (front_cmd),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_not_empty),
    .head      (head_cmd)
  );

  swpr_back #(
    .PAYLOAD_MAX (PAYLOAD_MAX),
    .MESSAGE_MAX (MESSAGE_MAX)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (q_not_empty),
    .cmd       (head_cmd),
    .cmd_pop   (q_pop),
    .res_valid (m_tvalid),
    .res       (res),
    .res_ready (m_tready)
  );

  assign m_tdata = {7'd0, res.message_length, res.write_byte, res.write_address};
  assign m_tuser = {res.byte_valid, res.event_kind};
  assign m_tlast = res.message_done;

endmodule

// ----- src/swpr_front.sv -----
// Front end of the packet receiver: classifies each incoming transfer.
// Turns the packet kind into a command for the execution side.
// Depends on swpr_pkg.
module swpr_front (
  input  logic [2:0]    kind,
  input  logic [7:0]    data,
  input  logic          last,
  input  logic [31:0]   carried,
  output swpr_pkg::cmd_t cmd
);

  always_comb begin
    cmd.data    = data;
    cmd.last    = last;
    cmd.carried = carried;
    case (kind)
      swpr_pkg::KIND_DATA:      cmd.op = swpr_pkg::OP_DATA;
      swpr_pkg::KIND_LAST_DATA: cmd.op = swpr_pkg::OP_FINAL;
      swpr_pkg::KIND_PEER_ACK:  cmd.op = swpr_pkg::OP_PEER_ACK;
      swpr_pkg::KIND_PEER_NACK: cmd.op = swpr_pkg::OP_PEER_NACK;
      swpr_pkg::KIND_TERM:      cmd.op = swpr_pkg::OP_TERM;
      default:                  cmd.op = swpr_pkg::OP_NONE;
    endcase
  end

endmodule

// ----- src/swpr_queue.sv -----
// Two-entry command queue between the front end and the execution side.
// Lets either side stall on its own. Depends on swpr_pkg.
module swpr_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  swpr_pkg::cmd_t push_cmd,
  output logic           full,
  input  logic           pop,
  output logic           not_empty,
  output swpr_pkg::cmd_t head
);

  swpr_pkg::cmd_t entries [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  assign full      = (count == 2'd2);
  assign not_empty = (count != 2'd0);
  assign head      = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

// ----- src/swpr_back.sv -----
// Execution side of the packet receiver: checksum, staging and commit logic.
// Holds the packet state and the registered result. Depends on swpr_pkg.
module swpr_back #(
  parameter int PAYLOAD_MAX = 1024,
  parameter int MESSAGE_MAX = 65536
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              cmd_valid,
  input  swpr_pkg::cmd_t    cmd,
  output logic              cmd_pop,
  output logic              res_valid,
  output swpr_pkg::result_t res,
  input  logic              res_ready
);

  localparam int IW = $clog2(PAYLOAD_MAX + 1);
  localparam int CW = $clog2(MESSAGE_MAX + 1);
  localparam int AW = ((CW > IW) ? CW : IW) + 1;

  logic [31:0]       running_sum;
  logic [IW-1:0]     byte_index;
  logic [CW-1:0]     committed_length;
  logic              link_open;
  logic [31:0]       running_sum_next;
  logic [IW-1:0]     byte_index_next;
  logic [CW-1:0]     committed_length_next;
  logic              link_open_next;
  swpr_pkg::result_t res_next;

  logic [31:0]   sum_add;
  logic          idx_ok;
  logic [AW-1:0] addr_sum;
  logic          stage_ok;
  logic [IW-1:0] idx_inc;
  logic [AW-1:0] len_sum;
  logic [CW-1:0] len_sat;
  logic          sum_match;

  assign cmd_pop = cmd_valid && (!res_valid || res_ready);

  always_comb begin
    sum_add   = running_sum + {{24{cmd.data[7]}}, cmd.data};
    idx_ok    = byte_index < IW'(PAYLOAD_MAX);
    addr_sum  = AW'(committed_length) + AW'(byte_index);
    stage_ok  = idx_ok && (addr_sum < AW'(MESSAGE_MAX));
    idx_inc   = idx_ok ? IW'(byte_index + IW'(1)) : byte_index;
    len_sum   = AW'(committed_length) + AW'(idx_inc);
    len_sat   = (len_sum > AW'(MESSAGE_MAX)) ? CW'(MESSAGE_MAX) : CW'(len_sum);
    sum_match = (sum_add == cmd.carried);
  end

  always_comb begin
    running_sum_next      = running_sum;
    byte_index_next       = byte_index;
    committed_length_next = committed_length;
    link_open_next        = link_open;
    res_next = '0;
    res_next.message_length = swpr_pkg::LEN_W'(committed_length);
    if (!link_open) begin
      res_next.event_kind     = swpr_pkg::EV_CLOSED;
      res_next.message_length = '0;
    end else begin
      case (cmd.op)
        swpr_pkg::OP_TERM: begin
          link_open_next          = 1'b0;
          running_sum_next        = '0;
          byte_index_next         = '0;
          committed_length_next   = '0;
          res_next.event_kind     = swpr_pkg::EV_CLOSED;
          res_next.message_length = '0;
        end
        swpr_pkg::OP_PEER_ACK: begin
          res_next.event_kind = swpr_pkg::EV_PEER_ACKED;
        end
        swpr_pkg::OP_PEER_NACK: begin
          res_next.event_kind = swpr_pkg::EV_PEER_NACKED;
        end
        swpr_pkg::OP_DATA, swpr_pkg::OP_FINAL: begin
          res_next.byte_valid = stage_ok;
          if (stage_ok) begin
            res_next.write_address = swpr_pkg::ADDR_W'(addr_sum);
            res_next.write_byte    = cmd.data;
          end
          if (!cmd.last) begin
            res_next.event_kind = swpr_pkg::EV_STAGED;
            running_sum_next    = sum_add;
            byte_index_next     = idx_inc;
          end else begin
            running_sum_next = '0;
            byte_index_next  = '0;
            if (sum_match) begin
              res_next.event_kind     = swpr_pkg::EV_SEND_ACK;
              res_next.message_length = swpr_pkg::LEN_W'(len_sat);
              if (cmd.op == swpr_pkg::OP_FINAL) begin
                res_next.message_done = 1'b1;
                committed_length_next = '0;
              end else begin
                committed_length_next = len_sat;
              end
            end else begin
              res_next.event_kind = swpr_pkg::EV_SEND_NACK;
            end
          end
        end
        default: begin
          res_next.event_kind = swpr_pkg::EV_STAGED;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running_sum      <= '0;
      byte_index       <= '0;
      committed_length <= '0;
      link_open        <= 1'b1;
      res_valid        <= 1'b0;
    end else begin
      if (cmd_pop) begin
        running_sum      <= running_sum_next;
        byte_index       <= byte_index_next;
        committed_length <= committed_length_next;
        link_open        <= link_open_next;
        res_valid        <= 1'b1;
      end else if (res_ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_pop) begin
      res <= res_next;
    end
  end

endmodule
